/* design/fmri_pkg.sv */
// ----------------------------------------------------------------------------
// fmri_pkg
// shared types, codes and helpers of the fm sound chip register front end
// ----------------------------------------------------------------------------
package fmri_pkg;

  // host command codes
  typedef enum logic [1:0] {
    CMD_WRITE  = 2'd0,
    CMD_READ   = 2'd1,
    CMD_STATUS = 2'd2,
    CMD_RAISE  = 2'd3
  } cmd_t;

  // timer side effect of a write
  typedef enum logic [1:0] {
    TEV_NONE    = 2'd0,
    TEV_T1_LOAD = 2'd1,
    TEV_T2_LOAD = 2'd2,
    TEV_START   = 2'd3
  } tev_t;

  // register addresses with their own rules
  localparam logic [7:0] REG_TIMER1  = 8'h02;
  localparam logic [7:0] REG_TIMER2  = 8'h03;
  localparam logic [7:0] REG_TCTRL   = 8'h04;
  localparam logic [7:0] REG_KBD     = 8'h05;
  localparam logic [7:0] REG_MODE    = 8'h08;
  localparam logic [7:0] REG_DAC_HI  = 8'h15;
  localparam logic [7:0] REG_DAC_LO  = 8'h16;
  localparam logic [7:0] REG_DAC_EXP = 8'h17;
  localparam logic [7:0] REG_IO_DIR  = 8'h18;
  localparam logic [7:0] REG_IO_DATA = 8'h19;
  localparam logic [7:0] REG_RHYTHM  = 8'hBD;
  localparam logic [7:0] REG_LAST_FB = 8'hC8;

  // plainly stored control registers
  localparam logic [7:0] REG_TEST      = 8'h01;
  localparam logic [7:0] REG_SEL_FIRST = 8'h06;
  localparam logic [7:0] REG_SEL_LAST  = 8'h12;
  localparam logic [7:0] REG_SPARE     = 8'h1A;

  // a write or b write partner lives at addr ^ this
  localparam logic [7:0] CH_PAIR_BIT = 8'h10;

  localparam logic [7:0] RST_TCTRL   = 8'h18;
  localparam logic [7:0] RST_IO_DATA = 8'h0F;

  localparam logic [7:0] FLAG_TIMERS = 8'h78;
  localparam logic [7:0] FLAG_KEEP   = 8'h87;
  localparam logic [7:0] STATUS_ONES = 8'h06;
  localparam logic [7:0] IO_RD_ONES  = 8'hF0;
  localparam logic [7:0] DAC_LO_KEEP = 8'hC0;
  localparam logic [7:0] DAC_EXP_KEEP = 8'h07;

  localparam logic [4:0] NO_SLOT = 5'd18;

  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] addr;
    logic [7:0] wdata;
    logic [3:0] io_pins;
    logic [7:0] keyboard_in;
  } item_t;

  // control state kept in flops, plus shadows of registers used by logic
  typedef struct packed {
    logic [7:0] status;
    logic [7:0] mask;
    logic       irq;
    logic       dac_en;    // reg 0x08 bit2
    logic [1:0] dac_lo;    // reg 0x16 bits 7..6
    logic [2:0] dac_exp;   // reg 0x17 bits 2..0
    logic [3:0] io_dir;    // reg 0x18 low nibble
    logic [3:0] io_data;   // reg 0x19 low nibble
  } ctl_state_t;

  typedef struct packed {
    logic       en;
    logic [7:0] addr;
    logic [7:0] data;
  } wr_req_t;

  typedef struct packed {
    logic [7:0]        read_data;
    logic              irq;
    logic              dac_strobe;
    logic signed [15:0] dac_value;
    tev_t              timer_event;
    logic              timer1_run;
    logic              timer2_run;
    logic              io_strobe;
    logic [3:0]        io_direction;
    logic [3:0]        io_level;
    logic [4:0]        slot_target;
    logic [13:0]       channel_word;
  } result_t;

  // register file contents after reset
  function automatic logic [7:0] rf_reset_val(input logic [7:0] a);
    logic [7:0] v;
    v = 8'h00;
    if (a == REG_TCTRL) v = RST_TCTRL;
    if (a == REG_IO_DATA) v = RST_IO_DATA;
    return v;
  endfunction

  // operator slot of an operator register offset
  function automatic logic [4:0] slot_of(input logic [4:0] i);
    logic [1:0] row;
    logic [4:0] col;
    logic [4:0] s;
    row = i[4:3];
    case (i[2:0])
      3'd0:    col = 5'd0;
      3'd1:    col = 5'd2;
      3'd2:    col = 5'd4;
      3'd3:    col = 5'd1;
      3'd4:    col = 5'd3;
      3'd5:    col = 5'd5;
      default: col = NO_SLOT;
    endcase
    s = 5'({row, 2'b00}) + 5'({row, 1'b0}) + col;
    if (row == 2'd3 || col == NO_SLOT) s = NO_SLOT;
    return s;
  endfunction

endpackage

/* design/fmri_regmem.sv */
// ----------------------------------------------------------------------------
// fmri_regmem
// 256x8 register file: one write port, two registered read ports
// ----------------------------------------------------------------------------
module fmri_regmem
  import fmri_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  wr_req_t    wr,
  input  logic       rd_en,
  input  logic [7:0] rd_addr,
  output logic [7:0] rd0_data,   // entry at rd_addr
  output logic [7:0] rd1_data    // entry at rd_addr ^ 0x10
);

  logic [7:0] mem [256];
  logic [255:0] valid_r;

  logic [7:0] raw0_r, raw1_r, byp_r, addr_r;
  logic       vld0_r, vld1_r, hit0_r, hit1_r;
  logic [7:0] addr1;

  assign addr1 = rd_addr ^ CH_PAIR_BIT;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      raw0_r <= mem[rd_addr];
      raw1_r <= mem[addr1];
      vld0_r <= valid_r[rd_addr];
      vld1_r <= valid_r[addr1];
      hit0_r <= wr.en && (wr.addr == rd_addr);
      hit1_r <= wr.en && (wr.addr == addr1);
      byp_r  <= wr.data;
      addr_r <= rd_addr;
    end
  end

  // entries never written read as their reset value
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr.en) begin
      valid_r[wr.addr] <= 1'b1;
    end
  end

  assign rd0_data = hit0_r ? byp_r : (vld0_r ? raw0_r : rf_reset_val(addr_r));
  assign rd1_data = hit1_r ? byp_r :
                    (vld1_r ? raw1_r : rf_reset_val(addr_r ^ CH_PAIR_BIT));

endmodule

/* design/fmri_exec.sv */
// ----------------------------------------------------------------------------
// fmri_exec
// command evaluation: next control state, register file write and result
// ----------------------------------------------------------------------------
module fmri_exec
  import fmri_pkg::*;
(
  input  item_t      item,
  input  logic [7:0] rd0_data,
  input  logic [7:0] rd1_data,
  input  ctl_state_t ctl,
  output ctl_state_t ctl_nxt,
  output wr_req_t    wr,
  output result_t    res
);

  logic [7:0]         a, d, m, st;
  logic signed [17:0] dac_raw, dac_sh;
  logic [2:0]         sh;
  logic [12:0]        freq;
  logic               key;

  assign a = item.addr;
  assign d = item.wdata;
  assign m = ~d & FLAG_TIMERS;

  // dac sample from the new high byte and stored low/exponent bits
  assign sh      = 3'd7 - ctl.dac_exp;
  assign dac_raw = signed'({d, ctl.dac_lo, 8'h00});
  assign dac_sh  = dac_raw >>> sh;

  // partner register of a channel write is always on read port 1
  always_comb begin
    if (!a[4]) begin
      freq = {rd1_data[4:0], d};
      key  = rd1_data[5];
    end else begin
      freq = {d[4:0], rd1_data};
      key  = d[5];
    end
  end

  always_comb begin
    ctl_nxt = ctl;
    wr      = '{en: 1'b0, addr: a, data: d};
    res     = '0;
    res.timer_event = TEV_NONE;
    res.slot_target = NO_SLOT;
    st      = ctl.status;
    case (item.cmd)
      CMD_WRITE: begin
        case (a[7:5])
          3'b000: begin
            case (a)
              REG_TIMER1: begin
                wr.en = 1'b1;
                res.timer_event = TEV_T1_LOAD;
              end
              REG_TIMER2: begin
                wr.en = 1'b1;
                res.timer_event = TEV_T2_LOAD;
              end
              REG_TCTRL: begin
                if (d[7]) begin
                  // flag reset, byte not stored
                  st = ctl.status & ~FLAG_TIMERS;
                  if ((st & ctl.mask) == 8'h00) begin
                    st[7] = 1'b0;
                    ctl_nxt.irq = 1'b0;
                  end
                end else begin
                  st = ctl.status & (FLAG_KEEP | m);
                  ctl_nxt.mask = m;
                  if ((st & m) != 8'h00) begin
                    st[7] = 1'b1;
                    ctl_nxt.irq = 1'b1;
                  end else begin
                    st[7] = 1'b0;
                    ctl_nxt.irq = 1'b0;
                  end
                  wr.en = 1'b1;
                  res.timer_event = TEV_START;
                  res.timer1_run  = d[0];
                  res.timer2_run  = d[1];
                end
                ctl_nxt.status = st;
              end
              REG_MODE: begin
                wr.en = 1'b1;
                ctl_nxt.dac_en = d[2];
              end
              REG_DAC_HI: begin
                wr.en = 1'b1;
                if (ctl.dac_en) begin
                  res.dac_strobe = 1'b1;
                  if (dac_sh[17:15] == 3'b000 || dac_sh[17:15] == 3'b111) begin
                    res.dac_value = dac_sh[15:0];
                  end else if (dac_sh[17]) begin
                    res.dac_value = 16'sh8000;
                  end else begin
                    res.dac_value = 16'sh7FFF;
                  end
                end
              end
              REG_DAC_LO: begin
                wr.en   = 1'b1;
                wr.data = d & DAC_LO_KEEP;
                ctl_nxt.dac_lo = d[7:6];
              end
              REG_DAC_EXP: begin
                wr.en   = 1'b1;
                wr.data = d & DAC_EXP_KEEP;
                ctl_nxt.dac_exp = d[2:0];
              end
              REG_IO_DIR: begin
                wr.en = 1'b1;
                ctl_nxt.io_dir = d[3:0];
                res.io_strobe    = 1'b1;
                res.io_direction = d[3:0];
                res.io_level     = ctl.io_data;
              end
              REG_IO_DATA: begin
                wr.en = 1'b1;
                ctl_nxt.io_data = d[3:0];
                res.io_strobe    = 1'b1;
                res.io_direction = ctl.io_dir;
                res.io_level     = d[3:0];
              end
              default: begin
                // plain stores: 0x01, 0x06..0x12 and 0x1a
                wr.en = (a == REG_TEST) || (a == REG_SPARE) ||
                        (a >= REG_SEL_FIRST && a <= REG_SEL_LAST);
              end
            endcase
          end
          3'b001, 3'b010, 3'b011, 3'b100: begin
            wr.en = 1'b1;
            res.slot_target = slot_of(a[4:0]);
          end
          3'b101: begin
            if (a == REG_RHYTHM) begin
              wr.en = 1'b1;
            end else if (a[3:0] <= 4'd8) begin
              wr.en = 1'b1;
              res.channel_word = {key, freq};
            end
          end
          3'b110: begin
            wr.en = (a <= REG_LAST_FB);
          end
          default: begin
          end
        endcase
      end
      CMD_READ: begin
        if (a == REG_KBD) begin
          res.read_data = item.keyboard_in;
        end else if (a == REG_IO_DATA) begin
          res.read_data = {4'h0, (ctl.io_data & ctl.io_dir) | (item.io_pins & ~ctl.io_dir)}
                          | IO_RD_ONES;
        end else begin
          res.read_data = rd0_data;
        end
      end
      CMD_STATUS: begin
        res.read_data = (ctl.status & (FLAG_KEEP | ctl.mask)) | STATUS_ONES;
      end
      CMD_RAISE: begin
        st = ctl.status | d;
        if ((st & ctl.mask) != 8'h00) begin
          st[7] = 1'b1;
          ctl_nxt.irq = 1'b1;
        end
        ctl_nxt.status = st;
      end
      default: begin
      end
    endcase
    res.irq = ctl_nxt.irq;
  end

endmodule

/* design/fm_sound_chip_register_interface.sv */
// ----------------------------------------------------------------------------
// fm_sound_chip_register_interface
// host register front end of an fm sound chip
// ----------------------------------------------------------------------------
// usage:
//   the input stream carries one host command per beat: register write,
//   register read, status read, or raising of status flags by an event
//   source. the command code rides on in_tuser, address, data, i/o pin
//   levels and keyboard byte on in_tdata.
//   every command gives exactly one result beat: read byte, irq level, dac
//   sample, timer, i/o port, slot and channel word side effects of a write.
// pipeline and throughput:
//   the command is registered together with the register file read (address
//   and addr ^ 0x10), then evaluated into the output register. one command
//   per cycle is sustained while out_tready stays high; the register file
//   write port and the bypass from it keep back-to-back writes and reads
//   coherent.
// reset:
//   rst_n low clears the pipeline, status, mask, irq and the register file
//   valid bits; unwritten entries read as their reset values, so no
//   clearing pass is needed and input is taken right after reset.
// stall:
//   when out_tready is low the result holds, one more command is taken into
//   the input stage, then in_tready drops until the output drains.
// ----------------------------------------------------------------------------
module fm_sound_chip_register_interface
  import fmri_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // addr[7:0], wdata[15:8], io_pins[19:16],
                                  // keyboard_in[27:20], zeros
  input  logic [1:0]  in_tuser,   // cmd[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata   // read_data[7:0], irq[8], dac_strobe[9],
                                  // dac_value[25:10], timer_event[27:26],
                                  // timer1_run[28], timer2_run[29],
                                  // io_strobe[30], io_direction[34:31],
                                  // io_level[38:35], slot_target[43:39],
                                  // channel_word[57:44], zeros
);

  localparam ctl_state_t CTL_RESET = '{
    status: 8'h00, mask: 8'h00, irq: 1'b0, dac_en: 1'b0, dac_lo: 2'b00,
    dac_exp: 3'b000, io_dir: 4'h0, io_data: RST_IO_DATA[3:0]
  };

  logic       s1_valid_r, out_valid_r;
  item_t      s1_r;
  result_t    out_r;
  ctl_state_t ctl_r;

  ctl_state_t ctl_nxt;
  wr_req_t    exe_wr, mem_wr;
  result_t    res;
  logic [7:0] rd0_data, rd1_data;
  logic       in_fire, advance;

  // stage 1 moves on when the output register is free or being emptied
  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;
  assign in_fire   = in_tvalid && in_tready;

  // register file writes land only when the command retires
  assign mem_wr = '{en: exe_wr.en && advance, addr: exe_wr.addr, data: exe_wr.data};

  fmri_regmem u_regmem (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr       (mem_wr),
    .rd_en    (in_fire),
    .rd_addr  (in_tdata[7:0]),
    .rd0_data (rd0_data),
    .rd1_data (rd1_data)
  );

  fmri_exec u_exec (
    .item     (s1_r),
    .rd0_data (rd0_data),
    .rd1_data (rd1_data),
    .ctl      (ctl_r),
    .ctl_nxt  (ctl_nxt),
    .wr       (exe_wr),
    .res      (res)
  );

  // control flops
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      ctl_r       <= CTL_RESET;
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        ctl_r       <= ctl_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_r <= '{cmd: cmd_t'(in_tuser), addr: in_tdata[7:0], wdata: in_tdata[15:8],
                io_pins: in_tdata[19:16], keyboard_in: in_tdata[27:20]};
    end
    if (advance) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_r.channel_word, out_r.slot_target, out_r.io_level,
                       out_r.io_direction, out_r.io_strobe, out_r.timer2_run,
                       out_r.timer1_run, out_r.timer_event, out_r.dac_value,
                       out_r.dac_strobe, out_r.irq, out_r.read_data};

  // irq only stands while an unmasked flag and the summary bit are set
  a_irq_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_r.irq |-> (ctl_r.status[7] && ((ctl_r.status & ctl_r.mask) != 8'h00)))
    else $error("irq set without an unmasked status flag");

  // a command waiting in stage 1 keeps its fields
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !advance) |=> (s1_valid_r && $stable(s1_r)))
    else $error("stage 1 command lost or changed while stalled");

  // control state moves only when a command retires
  a_ctl_retire: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(ctl_r))
    else $error("control state changed without a retiring command");

endmodule
